/* hw/rtl/levels_remap_white_run_blanker_defines.svh */
// ----------------------------------------------------------------------------
// levels remap white run blanker assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef LEVELS_REMAP_WHITE_RUN_BLANKER_DEFINES_SVH
`define LEVELS_REMAP_WHITE_RUN_BLANKER_DEFINES_SVH
`ifndef SYNTHESIS
`define LRWB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LRWB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LRWB_ASSERT(label, prop, msg)
`define LRWB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hw/rtl/lrwb_pkg.sv */
// ----------------------------------------------------------------------------
// lrwb_pkg
// shared constants, types and helpers of the levels remap white run blanker
// ----------------------------------------------------------------------------
package lrwb_pkg;

    localparam int MAX_BANDS   = 4;
    localparam int BAND_FIELDS = 4;
    localparam int BAND_CAP    = (MAX_BANDS < BAND_FIELDS) ? MAX_BANDS : BAND_FIELDS;
    localparam int TBL_DEPTH   = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_OUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_IN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_OUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_IN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BELOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 3'd6;

    typedef logic [BAND_FIELDS-1:0][7:0] t_pixel;

    typedef struct packed {
        logic [7:0] bo;
        logic [7:0] bi;
        logic [7:0] wo;
        logic [8:0] wi;
        logic [8:0] zb;
    } t_levels;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic                   valid;
        t_pixel                 px;
        logic [BAND_FIELDS-1:0] mask;
        logic                   last;
    } t_req;

    typedef struct packed {
        logic flush;
        logic held;
    } t_front_stat;

    function automatic logic [2:0] bands_in_use(input logic [2:0] bc);
        logic [2:0] n;
        n = bc;
        if (n > 3'(BAND_CAP)) begin
            n = 3'(BAND_CAP);
        end
        return n;
    endfunction

endpackage

/* hw/rtl/lrwb_lane.sv */
// ----------------------------------------------------------------------------
// lrwb_lane
// one band lane: private copy of the levels table, registered lookup
// ----------------------------------------------------------------------------
module lrwb_lane (
    input  logic             i_clk,
    input  lrwb_pkg::t_tbl_wr i_wr,
    input  logic             i_rd_en,
    input  logic [7:0]       i_addr,
    output logic [7:0]       o_data
);
    import lrwb_pkg::*;

    logic [7:0] r_mem [0:TBL_DEPTH-1];
    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= r_mem[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/lrwb_builder.sv */
// ----------------------------------------------------------------------------
// lrwb_builder
// table sequencer: one entry per pass, ramp value by a radix-2 divider
// ----------------------------------------------------------------------------
module lrwb_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lrwb_pkg::t_levels i_lv,
    output lrwb_pkg::t_tbl_wr o_wr,
    output logic              o_busy
);
    import lrwb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_WR   = 4'b1000
    } t_bstate;

    t_bstate     r_state, n_state;
    logic [7:0]  r_idx, n_idx;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [17:0] r_rem, n_rem;
    logic [17:0] r_dsh, n_dsh;
    logic [7:0]  r_quo, n_quo;

    logic [7:0]         w_k;
    logic signed [8:0]  w_dw;
    logic [9:0]         w_den;
    logic signed [17:0] w_prod;
    logic signed [19:0] w_num;
    logic [19:0]        w_abs;
    logic [8:0]         w_round;
    logic signed [10:0] w_q;
    logic signed [10:0] w_v;
    logic signed [10:0] w_bo;
    logic signed [10:0] w_hi;
    logic signed [10:0] w_lo_ab;
    logic signed [10:0] w_hi_ab;
    logic signed [10:0] w_mid;
    logic signed [10:0] w_med;
    logic [7:0]         w_entry;

    // ramp numerator 2*(wo-bo)*(i-bi) + (wi-bi)
    assign w_k    = r_idx - i_lv.bi;
    assign w_dw   = $signed({1'b0, i_lv.wo}) - $signed({1'b0, i_lv.bo});
    assign w_den  = {1'b0, i_lv.wi} - {2'b00, i_lv.bi};
    assign w_prod = w_dw * $signed({1'b0, w_k});
    assign w_num  = $signed({w_prod[17], w_prod, 1'b0}) + $signed({10'd0, w_den});
    assign w_abs  = w_num[19] ? 20'(-w_num) : w_num;

    // floor of signed quotient, then clamp between bo and wo-1
    assign w_round = {1'b0, r_quo} + {8'd0, (r_neg && (r_rem != '0))};
    assign w_q     = r_neg ? -$signed({2'b00, w_round}) : $signed({2'b00, w_round});
    assign w_bo    = $signed({3'b000, i_lv.bo});
    assign w_v     = w_bo + w_q;
    assign w_hi    = $signed({3'b000, i_lv.wo}) - 11'sd1;
    assign w_lo_ab = (w_v < w_bo) ? w_v : w_bo;
    assign w_hi_ab = (w_v < w_bo) ? w_bo : w_v;
    assign w_mid   = (w_hi_ab < w_hi) ? w_hi_ab : w_hi;
    assign w_med   = (w_lo_ab > w_mid) ? w_lo_ab : w_mid;

    always_comb begin
        if ({1'b0, r_idx} < i_lv.zb) begin
            w_entry = 8'd0;
        end else if ({1'b0, r_idx} >= i_lv.wi) begin
            w_entry = i_lv.wo;
        end else if (r_idx < i_lv.bi) begin
            w_entry = i_lv.bo;
        end else begin
            w_entry = w_med[7:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_quo   = r_quo;
        case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_MUL: begin
                n_neg   = w_num[19];
                n_rem   = w_abs[17:0];
                n_dsh   = {w_den, 8'd0};
                n_quo   = '0;
                n_cnt   = 3'd7;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_rem >= r_dsh) begin
                    n_rem = r_rem - r_dsh;
                    n_quo = {r_quo[6:0], 1'b1};
                end else begin
                    n_quo = {r_quo[6:0], 1'b0};
                end
                n_dsh = {1'b0, r_dsh[17:1]};
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == '0) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                if (r_idx == 8'(TBL_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + 8'd1;
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_start) begin
            n_state = ST_MUL;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
    end

    assign o_wr.we   = (r_state == ST_WR);
    assign o_wr.addr = r_idx;
    assign o_wr.data = w_entry;
    assign o_busy    = (r_state != ST_IDLE);

endmodule

/* hw/rtl/lrwb_front.sv */
// ----------------------------------------------------------------------------
// lrwb_front
// white detect, one-pixel hold and row-end flush, issues lookup requests
// ----------------------------------------------------------------------------
module lrwb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_slot,
    input  lrwb_pkg::t_pixel      i_px,
    input  logic                  i_last,
    input  logic [7:0]            i_thr,
    input  logic [2:0]            i_bc,
    output lrwb_pkg::t_req        o_req,
    output lrwb_pkg::t_front_stat o_stat
);
    import lrwb_pkg::*;

    logic   r_held_v, n_held_v;
    logic   r_held_w, n_held_w;
    logic   r_left_w, n_left_w;
    logic   r_flush, n_flush;
    logic   r_flush_blank, n_flush_blank;
    t_pixel r_held_px, n_held_px;

    logic [2:0] w_n;
    logic [9:0] w_sum;
    logic [9:0] w_thr_n;
    logic       w_white;
    logic       w_left_new;

    function automatic logic [BAND_FIELDS-1:0] band_mask(input logic [2:0] n,
                                                         input logic blank);
        logic [BAND_FIELDS-1:0] m;
        for (int b = 0; b < BAND_FIELDS; b++) begin
            m[b] = (3'(b) < n) && !blank;
        end
        return m;
    endfunction

    assign w_n = bands_in_use(i_bc);

    always_comb begin
        w_sum = '0;
        for (int b = 0; b < BAND_FIELDS; b++) begin
            if (3'(b) < w_n) begin
                w_sum = w_sum + {2'b00, i_px[b]};
            end
        end
    end

    assign w_thr_n    = 10'({2'b00, i_thr} * {7'd0, w_n});
    assign w_white    = (i_thr != '0) && (w_sum >= w_thr_n);
    assign w_left_new = r_held_v ? r_held_w : r_left_w;

    always_comb begin
        o_req         = '0;
        n_held_v      = r_held_v;
        n_held_w      = r_held_w;
        n_left_w      = r_left_w;
        n_flush       = r_flush;
        n_flush_blank = r_flush_blank;
        n_held_px     = r_held_px;
        if (r_flush) begin
            if (i_slot) begin
                o_req.valid = 1'b1;
                o_req.px    = r_held_px;
                o_req.mask  = band_mask(w_n, r_flush_blank);
                o_req.last  = 1'b1;
                n_flush     = 1'b0;
            end
        end else if (i_accept) begin
            n_held_px = i_px;
            if (r_held_v) begin
                o_req.valid = 1'b1;
                o_req.px    = r_held_px;
                o_req.mask  = band_mask(w_n, r_held_w && (r_left_w || w_white));
                o_req.last  = 1'b0;
                if (i_last) begin
                    n_flush       = 1'b1;
                    n_flush_blank = w_white && w_left_new;
                end
            end else if (i_last) begin
                o_req.valid = 1'b1;
                o_req.px    = i_px;
                o_req.mask  = band_mask(w_n, w_white && w_left_new);
                o_req.last  = 1'b1;
            end
            if (i_last) begin
                n_held_v = 1'b0;
                n_held_w = 1'b0;
                n_left_w = 1'b0;
            end else begin
                n_held_v = 1'b1;
                n_held_w = w_white;
                n_left_w = w_left_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_held_w <= 1'b0;
            r_left_w <= 1'b0;
            r_flush  <= 1'b0;
        end else begin
            r_held_v <= n_held_v;
            r_held_w <= n_held_w;
            r_left_w <= n_left_w;
            r_flush  <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_px     <= n_held_px;
        r_flush_blank <= n_flush_blank;
    end

    assign o_stat.flush = r_flush;
    assign o_stat.held  = r_held_v;

endmodule

/* hw/rtl/levels_remap_white_run_blanker.sv */
// ----------------------------------------------------------------------------
// levels_remap_white_run_blanker: per-band levels remap with white-run blanking
// a pixel passes the request, lane read and output registers once a transaction
// releases it; 1 pixel per cycle unless a stall, table build or flush holds
// input; a row end flushes the second pixel in its own front slot; reset and
// each register write rebuild all 256 entries, o_in_ready low; config always taken
// ----------------------------------------------------------------------------
`include "levels_remap_white_run_blanker_defines.svh"

module levels_remap_white_run_blanker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lrwb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrwb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_band_zero,
    input  logic [7:0]                     i_band_one,
    input  logic [7:0]                     i_band_two,
    input  logic [7:0]                     i_band_three,
    input  logic                           i_row_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_band_zero,
    output logic [7:0]                     o_out_band_one,
    output logic [7:0]                     o_out_band_two,
    output logic [7:0]                     o_out_band_three,
    output logic                           o_out_row_end
);
    import lrwb_pkg::*;

    logic [7:0] r_bo, r_bi, r_wo, r_thr;
    logic [8:0] r_wi, r_zb;
    logic [2:0] r_bc;

    logic        w_cfg_acc;
    logic        w_start;
    t_levels     w_lv;
    t_tbl_wr     w_wr;
    logic        w_busy;
    t_pixel      w_px;
    t_req        w_req;
    t_front_stat w_stat;
    logic        w_in_acc;
    logic        w_out_load;
    logic        w_s2_load;
    logic        w_s1_load;
    t_pixel      w_rd;

    logic                   r_s1_v;
    t_pixel                 r_s1_px;
    logic [BAND_FIELDS-1:0] r_s1_mask;
    logic                   r_s1_last;
    logic                   r_s2_v;
    logic [BAND_FIELDS-1:0] r_s2_mask;
    logic                   r_s2_last;
    logic                   r_out_v;
    t_pixel                 r_out_band;
    logic                   r_out_last;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        w_start = 1'b0;
        if (w_cfg_acc) begin
            case (i_cfg_index)
                CFG_BLACK_OUT, CFG_BLACK_IN, CFG_WHITE_OUT, CFG_WHITE_IN,
                CFG_ZERO_BELOW, CFG_WHITE_THR, CFG_BAND_COUNT: begin
                    w_start = 1'b1;
                end
                default: begin
                    w_start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bo  <= 8'd0;
            r_bi  <= 8'd0;
            r_wo  <= 8'd255;
            r_wi  <= 9'd256;
            r_zb  <= 9'd0;
            r_thr <= 8'd0;
            r_bc  <= 3'd3;
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                CFG_BLACK_OUT:  r_bo  <= i_cfg_data[7:0];
                CFG_BLACK_IN:   r_bi  <= i_cfg_data[7:0];
                CFG_WHITE_OUT:  r_wo  <= i_cfg_data[7:0];
                CFG_WHITE_IN:   r_wi  <= i_cfg_data;
                CFG_ZERO_BELOW: r_zb  <= i_cfg_data;
                CFG_WHITE_THR:  r_thr <= i_cfg_data[7:0];
                CFG_BAND_COUNT: r_bc  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign w_lv.bo = r_bo;
    assign w_lv.bi = r_bi;
    assign w_lv.wo = r_wo;
    assign w_lv.wi = r_wi;
    assign w_lv.zb = r_zb;

    lrwb_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_lv    (w_lv),
        .o_wr    (w_wr),
        .o_busy  (w_busy)
    );

    // pipeline flow control
    assign w_out_load = !r_out_v || i_out_ready;
    assign w_s2_load  = !r_s2_v || w_out_load;
    assign w_s1_load  = !r_s1_v || w_s2_load;
    assign o_in_ready = w_s1_load && !w_busy && !w_stat.flush;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_px[0] = i_band_zero;
    assign w_px[1] = i_band_one;
    assign w_px[2] = i_band_two;
    assign w_px[3] = i_band_three;

    lrwb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_slot   (w_s1_load),
        .i_px     (w_px),
        .i_last   (i_row_end),
        .i_thr    (r_thr),
        .i_bc     (r_bc),
        .o_req    (w_req),
        .o_stat   (w_stat)
    );

    // request stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_v <= w_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_px   <= w_req.px;
            r_s1_mask <= w_req.mask;
            r_s1_last <= w_req.last;
        end
    end

    // table lanes
    for (genvar b = 0; b < BAND_FIELDS; b++) begin : g_lane
        lrwb_lane u_lane (
            .i_clk   (i_clk),
            .i_wr    (w_wr),
            .i_rd_en (w_s2_load),
            .i_addr  (r_s1_px[b]),
            .o_data  (w_rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_load) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_s2_mask <= r_s1_mask;
            r_s2_last <= r_s1_last;
        end
    end

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int b = 0; b < BAND_FIELDS; b++) begin
                r_out_band[b] <= r_s2_mask[b] ? w_rd[b] : 8'd0;
            end
            r_out_last <= r_s2_last;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_out_band_zero  = r_out_band[0];
    assign o_out_band_one   = r_out_band[1];
    assign o_out_band_two   = r_out_band[2];
    assign o_out_band_three = r_out_band[3];
    assign o_out_row_end    = r_out_last;

    `LRWB_ASSERT_ALWAYS(a_reset_rebuilds, !i_rst_n |=> w_busy, "table rebuild not started by reset")
    `LRWB_ASSERT(a_row_end_splits, w_in_acc && i_row_end && w_stat.held |=> w_stat.flush && r_s1_v && !r_s1_last, "row end with held pixel did not split")
    `LRWB_ASSERT(a_flush_ends_row, w_stat.flush && w_s1_load |=> r_s1_v && r_s1_last && !w_stat.flush, "flushed pixel not issued as row end")

endmodule
